[rtl/core/blzd_pkg.sv]
// package for the backward lzss decompressor: item types, sequencer states,
// token constants and the check result struct; no dependencies
`timescale 1ns / 1ps

package blzd_pkg;

	localparam int HISTORY_DEPTH = 8192;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

	localparam logic [7:0]  FLAG_MSB    = 8'h80;
	localparam logic [11:0] OFFSET_MASK = 12'hFFF;
	localparam logic [4:0]  LEN_BIAS    = 5'd3;
	localparam logic [12:0] DIST_BIAS   = 13'd3;
	localparam logic [3:0]  FLAGS_FULL  = 4'd8;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       byte_valid;
		logic       run_end;
		logic       stream_end;
		logic       failed;
	} out_item_t;

	// result of the token check unit
	typedef struct packed {
		logic        room_nz;
		logic        copy_bad;
		logic [4:0]  len;
		logic [12:0] back_dist;
	} check_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_LIT    = 6'b000100,
		S_RD     = 6'b001000,
		S_WR     = 6'b010000,
		S_STAT   = 6'b100000
	} state_t;

endpackage

[rtl/core/backward_lzss_decompressor.sv]
// backward lzss decompressor top level: sequencer, history ram, output register
// sequence: each request is accepted, then decoded; a literal adds an emit step, each copied byte
// a history read then write, and a final or failed request a status item; emit steps wait on out_free
// throughput: one request at a time, bound by the single history ram port pair
// reset: arst_n clears control state and output_size; history is undefined until written
// depends on blzd_pkg, blzd_ram, blzd_check
`timescale 1ns / 1ps

module backward_lzss_decompressor
	import blzd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// compressed byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	// decompressed byte channel
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	// output_size register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	// sequencer and decoder state
	state_t          state_q;
	logic [31:0]     output_size_q;
	logic [31:0]     produced_q;
	logic [HIST_AW-1:0] wp_q;       // history write pointer, produced count mod depth
	logic [7:0]      flag_byte_q;
	logic [3:0]      flags_left_q;
	logic            awaiting_low_q;
	logic [7:0]      held_high_q;
	logic            error_q;

	// current request
	logic [7:0]      byte_q;
	logic            fin_q;

	// copy control
	logic [4:0]      cnt_q;
	logic [12:0]     dist_q;

	// output register
	logic            ovalid_q;
	out_item_t       out_q;

	check_t          chk;
	logic            out_free;
	logic            active;
	logic            load_out;
	out_item_t       load_item;

	// history ram ports
	logic               ram_we;
	logic [HIST_AW-1:0] ram_waddr;
	logic [7:0]         ram_wdata;
	logic               ram_re;
	logic [HIST_AW-1:0] ram_raddr;
	logic [7:0]         ram_rdata;
	logic [HIST_AW:0]   back_addr;

	blzd_check u_check (
		.output_size (output_size_q),
		.produced    (produced_q),
		.held_high   (held_high_q),
		.low_byte    (byte_q),
		.chk         (chk)
	);

	blzd_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshakes: one request in flight, config always taken (to be written only when idle, left to the user)
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_item  = out_q;

	// output register can take a new item when empty or being drained
	assign out_free = !ovalid_q || !out_stall;

	// the decoder acts only without an error and with budget left
	assign active = !error_q && chk.room_nz;

	// copy source: write pointer minus distance, wrapped into the history depth
	always_comb begin
		back_addr = {1'b0, wp_q} - {{(HIST_AW + 1 - 13){1'b0}}, dist_q};
		if (back_addr[HIST_AW]) begin
			back_addr = back_addr + (HIST_AW + 1)'(HISTORY_DEPTH);
		end
	end

	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = back_addr[HIST_AW-1:0];
	assign ram_waddr = wp_q;

	// byte emission: literal or copied byte, and the status item
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = byte_q;
		load_out  = 1'b0;
		load_item = '0;
		case (state_q)
			S_LIT: begin
				if (out_free) begin
					ram_we              = 1'b1;
					load_out            = 1'b1;
					load_item.plain_byte = byte_q;
					load_item.byte_valid = 1'b1;
					load_item.run_end    = !fin_q;
					load_item.failed     = error_q;
				end
			end
			S_WR: begin
				ram_wdata = ram_rdata;
				if (out_free) begin
					ram_we              = 1'b1;
					load_out            = 1'b1;
					load_item.plain_byte = ram_rdata;
					load_item.byte_valid = 1'b1;
					load_item.run_end    = (cnt_q == 5'd1) && !fin_q;
					load_item.failed     = error_q;
				end
			end
			S_STAT: begin
				if (out_free) begin
					load_out             = 1'b1;
					load_item.run_end    = 1'b1;
					load_item.stream_end = fin_q;
					load_item.failed     = error_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= load_item;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			output_size_q  <= '0;
			produced_q     <= '0;
			wp_q           <= '0;
			flag_byte_q    <= '0;
			flags_left_q   <= '0;
			awaiting_low_q <= 1'b0;
			held_high_q    <= '0;
			error_q        <= 1'b0;
			byte_q         <= '0;
			fin_q          <= 1'b0;
			cnt_q          <= '0;
			dist_q         <= '0;
			ovalid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				output_size_q <= cfg_data;
			end

			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			// every written history byte advances the count and the pointer
			if (ram_we) begin
				produced_q <= produced_q + 32'd1;
				if (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + HIST_AW'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q      <= in_item.packed_byte;
						fin_q       <= in_item.final_byte;
						state_q     <= S_DECODE;
					end
				end
				S_DECODE: begin
					// default: nothing to emit, status only if final
					state_q <= fin_q ? S_STAT : S_IDLE;
					if (active) begin
						if (flags_left_q == 4'd0) begin
							// control byte
							flag_byte_q  <= byte_q;
							flags_left_q <= FLAGS_FULL;
						end else if (awaiting_low_q) begin
							// low byte of a reference
							awaiting_low_q <= 1'b0;
							if (chk.copy_bad) begin
								error_q <= 1'b1;
								state_q <= S_STAT;
							end else begin
								flag_byte_q  <= {flag_byte_q[6:0], 1'b0};
								flags_left_q <= flags_left_q - 4'd1;
								cnt_q        <= chk.len;
								dist_q       <= chk.back_dist;
								state_q      <= S_RD;
							end
						end else if ((flag_byte_q & FLAG_MSB) != 8'd0) begin
							// high byte of a reference, cut token if final
							held_high_q    <= byte_q;
							awaiting_low_q <= 1'b1;
							if (fin_q) begin
								error_q <= 1'b1;
							end
						end else begin
							// literal
							flag_byte_q  <= {flag_byte_q[6:0], 1'b0};
							flags_left_q <= flags_left_q - 4'd1;
							state_q      <= S_LIT;
						end
					end
					// end of region drops any partial control state
					if (fin_q) begin
						flags_left_q   <= '0;
						awaiting_low_q <= 1'b0;
					end
				end
				S_LIT: begin
					if (out_free) begin
						state_q <= fin_q ? S_STAT : S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == 5'd1) begin
							state_q <= fin_q ? S_STAT : S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/blzd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module blzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/blzd_check.sv]
// token check unit: copy length, distance, remaining budget and error test
// depends on blzd_pkg
`timescale 1ns / 1ps

module blzd_check
	import blzd_pkg::*;
(
	input  logic [31:0] output_size,
	input  logic [31:0] produced,
	input  logic [7:0]  held_high,
	input  logic [7:0]  low_byte,
	output check_t      chk
);

	logic [31:0] room;
	logic [11:0] offset;

	always_comb begin
		offset        = {held_high[3:0], low_byte} & OFFSET_MASK;
		room          = output_size - produced;
		chk.room_nz   = output_size > produced;
		chk.len       = {1'b0, held_high[7:4]} + LEN_BIAS;
		chk.back_dist = {1'b0, offset} + DIST_BIAS;
		chk.copy_bad  = ({27'd0, chk.len} > room) || ({19'd0, chk.back_dist} > produced);
	end

endmodule

[tb/backward_lzss_decompressor_tb.sv]
// testbench for backward_lzss_decompressor: a clocked driver and monitor around the block,
// a bit-true predictor of the byte stream, and phases with different output budgets
// depends on blzd_pkg and the rtl of the block
`timescale 1ns / 1ps

module backward_lzss_decompressor_tb;
	import blzd_pkg::*;

	// cycles without any accepted request, result or config write before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// cycles the receiver holds off during the pressure phase
	localparam int HOLD_CYCLES = 400;
	// cycles to let the block finish a request that gives no result
	localparam int DRAIN_CYCLES = 60;
	// percent of cycles in which a side idles
	localparam int IDLE_PCT = 18;

	typedef enum int {
		OVER_BUDGET,
		FAR_DISTANCE,
		CUT_TOKEN
	} fault_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// pacing controls
	logic calm = 1'b0;      // no idling on either side while set
	logic hold_arm = 1'b0;  // starts the long receiver hold-off
	logic hold_on = 1'b0;

	in_item_t  pending[$];    // compressed bytes not yet offered
	out_item_t due_items[$];  // decompressed items still to arrive
	int        fed = 0;
	int        misses = 0;
	int        idle_cycles = 0;

	// predicted block state
	logic [7:0]  plain_hist [0:HISTORY_DEPTH-1];
	logic [31:0] plain_count = '0;
	logic [7:0]  ctl_bits = '0;
	logic [3:0]  ctl_left = '0;
	logic        low_pending = 1'b0;
	logic [7:0]  token_high = '0;
	logic        err_sticky = 1'b0;
	logic [31:0] size_limit = '0;

	// stream generator shadow, resynced from the prediction between phases
	longint      gen_count = 0;
	logic [31:0] gen_size = '0;

	backward_lzss_decompressor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected items for one accepted compressed byte
	task automatic lzss_expand(input in_item_t req);
		out_item_t   burst [0:18];
		logic [31:0] room;
		logic [31:0] copy_len;
		logic [31:0] copy_dist;
		logic [31:0] src;
		logic [7:0]  data;
		logic        was_err;
		logic        is_copy;
		int          n_bytes;
		int          n;
		was_err = err_sticky;
		room = (size_limit > plain_count) ? size_limit - plain_count : 32'd0;
		n_bytes = 0;
		n = 0;
		is_copy = 1'b0;
		copy_dist = '0;
		// spent budget or a set error swallows the byte, control bytes too
		if (!err_sticky && room != 32'd0) begin
			if (ctl_left == 4'd0) begin
				ctl_bits = req.packed_byte;
				ctl_left = FLAGS_FULL;
			end else if (low_pending) begin
				copy_len = {28'd0, token_high[7:4]} + LEN_BIAS;
				copy_dist = ({16'd0, token_high, req.packed_byte} & OFFSET_MASK) + DIST_BIAS;
				low_pending = 1'b0;
				// too long for the budget or reaching behind produced data
				if (copy_len > room || copy_dist > plain_count) begin
					err_sticky = 1'b1;
				end else begin
					n_bytes = copy_len;
					is_copy = 1'b1;
				end
			end else if ((ctl_bits & FLAG_MSB) != 8'd0) begin
				token_high = req.packed_byte;
				low_pending = 1'b1;
				// token cut off by the end of the region
				if (req.final_byte)
					err_sticky = 1'b1;
			end else begin
				n_bytes = 1;
			end
		end
		if (n_bytes != 0) begin
			ctl_bits = ctl_bits << 1;
			ctl_left = ctl_left - 4'd1;
		end
		for (int i = 0; i < n_bytes; i++) begin
			src = plain_count - copy_dist;
			data = is_copy ? plain_hist[src[HIST_AW-1:0]] : req.packed_byte;
			plain_hist[plain_count[HIST_AW-1:0]] = data;
			plain_count = plain_count + 32'd1;
			burst[n] = '{plain_byte: data, byte_valid: 1'b1, run_end: 1'b0,
				stream_end: 1'b0, failed: err_sticky};
			n++;
		end
		// region end resets the token parser only
		if (req.final_byte) begin
			ctl_left = 4'd0;
			low_pending = 1'b0;
		end
		if (req.final_byte || (err_sticky && !was_err)) begin
			burst[n] = '{plain_byte: 8'h00, byte_valid: 1'b0, run_end: 1'b0,
				stream_end: req.final_byte, failed: err_sticky};
			n++;
		end
		if (n > 0)
			burst[n-1].run_end = 1'b1;
		for (int i = 0; i < n; i++)
			due_items.push_back(burst[i]);
	endtask

	// driver: offers queued bytes, predicts each accepted request
	always @(posedge clk or negedge arst_n) begin : drive
		in_item_t nxt_item;
		logic     nxt_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nxt_valid = in_valid;
			nxt_item = in_item;
			if (in_valid && !in_stall) begin
				lzss_expand(in_item);
				nxt_valid = 1'b0;
			end
			// a stalled request keeps its payload; a new one may be delayed at random
			if (!nxt_valid && pending.size() != 0 &&
					(calm || $urandom_range(99) >= IDLE_PCT)) begin
				nxt_item = pending.pop_front();
				nxt_valid = 1'b1;
			end
			in_valid <= nxt_valid;
			in_item <= nxt_item;
		end
	end

	// monitor: checks each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_items.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("unexpected result: byte %h valid %b run_end %b stream_end %b failed %b",
							out_item.plain_byte, out_item.byte_valid, out_item.run_end,
							out_item.stream_end, out_item.failed);
				end else begin
					want = due_items.pop_front();
					if (out_item.plain_byte !== want.plain_byte ||
							out_item.byte_valid !== want.byte_valid ||
							out_item.run_end !== want.run_end ||
							out_item.stream_end !== want.stream_end ||
							out_item.failed !== want.failed) begin
						misses++;
						if (misses <= 10)
							$display("mismatch: got %h %b %b %b %b, expected %h %b %b %b %b",
								out_item.plain_byte, out_item.byte_valid, out_item.run_end,
								out_item.stream_end, out_item.failed, want.plain_byte,
								want.byte_valid, want.run_end, want.stream_end, want.failed);
					end
				end
			end
			if (hold_on)
				out_stall <= 1'b1;
			else if (calm)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// long receiver hold-off, counted here so the sender keeps going
	initial begin : hold_off
		do @(posedge clk); while (!hold_arm);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// watchdog on request progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL backward_lzss_decompressor");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		pending.push_back('{packed_byte: b, final_byte: fin});
		fed++;
	endtask

	// one control byte and its tokens; a short group ends the region early
	task automatic push_group(input bit fin_at_end, input int n_tok, input int copy_pct);
		logic [7:0]  ctl;
		logic [11:0] off;
		bit          tok_copy [0:7];
		int          tok_len [0:7];
		int          tok_dist [0:7];
		int          reach;
		longint      room;
		ctl = 8'($urandom);
		for (int i = 0; i < n_tok; i++) begin
			tok_len[i] = $urandom_range(18, 3);
			room = longint'(gen_size) - gen_count;
			tok_copy[i] = gen_count >= 3 && room >= tok_len[i] &&
				$urandom_range(99) < copy_pct;
			if (tok_copy[i]) begin
				reach = (gen_count > 4098) ? 4098 : int'(gen_count);
				tok_dist[i] = ($urandom_range(9) == 0) ? reach : $urandom_range(reach, 3);
				gen_count += tok_len[i];
			end else begin
				gen_count += 1;
			end
			ctl[7-i] = tok_copy[i];
		end
		push_byte(ctl, fin_at_end && n_tok == 0);
		for (int i = 0; i < n_tok; i++) begin
			if (tok_copy[i]) begin
				off = 12'(tok_dist[i] - 3);
				push_byte({4'(tok_len[i] - 3), off[11:8]}, 1'b0);
				push_byte(off[7:0], fin_at_end && i == n_tok - 1);
			end else begin
				push_byte(8'($urandom), fin_at_end && i == n_tok - 1);
			end
		end
	endtask

	// well-formed regions with random content, some cut short at a token boundary
	task automatic random_regions(input int quota);
		int start;
		int groups;
		start = fed;
		while (fed - start < quota) begin
			groups = $urandom_range(4, 1);
			for (int g = 0; g < groups - 1; g++)
				push_group(1'b0, 8, 55);
			push_group(1'b1, ($urandom_range(3) == 0) ? $urandom_range(7, 0) : 8, 55);
		end
	endtask

	// wait for every request to be taken and every result to arrive
	task automatic settle();
		do @(posedge clk); while (pending.size() != 0 || in_valid || due_items.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		gen_count = longint'(plain_count);
	endtask

	task automatic write_size(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_limit = v;
		gen_size = v;
	endtask

	initial begin : stimulus
		fault_kind_t fault;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero budget: bytes are dropped, the final one still reports
		write_size(32'd0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		settle();

		// open budget: literal extremes, shortest and longest copies
		write_size(32'hFFFF_FFFF);
		push_byte(8'h03, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h06, 1'b0);
		// copy whose low byte ends the region
		push_byte(8'h80, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h0F, 1'b1);
		// region ending on a control byte, then on a literal
		push_byte(8'h55, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b1);
		settle();

		// steady stretch without any idling
		calm <= 1'b1;
		random_regions(90);
		settle();
		calm <= 1'b0;

		// receiver holds off while the sender keeps offering
		random_regions(50);
		@(posedge clk);
		hold_arm <= 1'b1;
		settle();

		// budget runs out in the middle of literals, the rest is dropped
		write_size(plain_count + 32'd40);
		for (int g = 0; g < 6; g++)
			push_group(1'b0, 8, 0);
		push_byte(8'h3C, 1'b1);
		settle();

		// copy that exactly fills the budget
		write_size(plain_count + 32'd18);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h99, 1'b0);
		push_byte(8'h42, 1'b1);
		settle();

		// budget lowered below what was produced counts as spent
		write_size(plain_count - 32'd5);
		push_byte(8'h00, 1'b0);
		push_byte(8'hC3, 1'b1);
		settle();

		// moderate budget
		write_size(plain_count + 32'd1500);
		random_regions(70);
		settle();

		write_size(32'hFFFF_FFFF);
		random_regions(50);
		settle();

		// one sticky error per run, kind picked by the seed
		fault = fault_kind_t'($urandom_range(2));
		if (fault == FAR_DISTANCE && plain_count >= 32'd4098)
			fault = OVER_BUDGET;
		case (fault)
			OVER_BUDGET: begin
				write_size(plain_count + 32'd5);
				push_byte(8'h80, 1'b0);
				push_byte(8'hF0, 1'b0);
				push_byte(8'h00, 1'b0);
			end
			FAR_DISTANCE: begin
				push_byte(8'h80, 1'b0);
				push_byte(8'h0F, 1'b0);
				push_byte(8'hFF, 1'b0);
			end
			default: begin
				push_byte(8'h80, 1'b0);
				push_byte(8'h37, 1'b1);
			end
		endcase
		// everything after the error is dropped
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b1);
		settle();

		if (misses == 0 && due_items.size() == 0)
			$display("PASS backward_lzss_decompressor");
		else
			$display("FAIL backward_lzss_decompressor");
		$finish;
	end

endmodule
